FILE: src/assert_macros.svh
// assertion helpers for the plane transposer checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define IPT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form built on the one above
`define IPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	`IPT_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

FILE: src/ipt_pkg.sv
// ----------------------------------------------------------------------------
// ipt_pkg
// Shared types and constants of the image plane transposer.
// ----------------------------------------------------------------------------
package ipt_pkg;

	localparam int MAX_WIDTH   = 64;
	localparam int MAX_HEIGHT  = 64;
	localparam int PIXEL_BITS  = 64;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
	localparam int CNT_BITS    = ADDR_BITS + 1;
	localparam int DIM_BITS    = 7;
	localparam int POS_BITS    = 6;
	localparam int CFG_BITS    = 7;
	localparam int OQ_DEPTH    = 4;

	typedef logic [63:0] pixel_t;

	localparam pixel_t PIX_MASK = {64{1'b1}} >> (64 - PIXEL_BITS);

	typedef enum logic [1:0] {
		REG_IN_WIDTH  = 2'd0,
		REG_IN_HEIGHT = 2'd1,
		REG_DIR_MODE  = 2'd2,
		REG_PASS_MODE = 2'd3
	} reg_idx_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_EMIT = 1'b1
	} cmd_t;

	localparam logic [1:0] PASS_ALWAYS    = 2'd0;
	localparam logic [1:0] KEEP_LANDSCAPE = 2'd1;
	localparam logic [1:0] KEEP_PORTRAIT  = 2'd2;

	typedef struct packed {
		logic                 wr;
		logic [ADDR_BITS-1:0] addr;
		pixel_t               data;
		logic                 last;
	} mem_req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		pixel_t pixel;
		logic   last;
	} out_item_t;

endpackage

FILE: src/ipt_front.sv
// ----------------------------------------------------------------------------
// ipt_front
// Takes requests and config writes, tracks load count and output position,
// makes store writes of loads until the frame is full, then reads of emits.
// ----------------------------------------------------------------------------
module ipt_front import ipt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                cmd,
	input  logic [63:0]         pixel_in,
	output logic                full,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	input  q_stat_t             q_stat,
	output logic                q_push,
	output mem_req_t            q_req
);

	logic [DIM_BITS-1:0] in_width_q, in_height_q;
	logic [2:0]          dir_mode_q;
	logic [1:0]          pass_mode_q;
	logic [CNT_BITS-1:0] load_count_q;
	logic [POS_BITS-1:0] out_row_q, out_col_q;

	logic [DIM_BITS-1:0]   w, h, outw, outh;
	logic [2*DIM_BITS-1:0] total;
	logic [1:0]            mode;
	logic                  pt, wrap, last, complete, accept, is_load, col_end;
	logic [POS_BITS-1:0]   r, c, srow, scol, row_sel, col_sel;
	logic [CNT_BITS-1:0]   rd_addr;

	always_comb begin
		if (in_width_q == '0) w = DIM_BITS'(1);
		else if (in_width_q > DIM_BITS'(MAX_WIDTH)) w = DIM_BITS'(MAX_WIDTH);
		else w = in_width_q;
		if (in_height_q == '0) h = DIM_BITS'(1);
		else if (in_height_q > DIM_BITS'(MAX_HEIGHT)) h = DIM_BITS'(MAX_HEIGHT);
		else h = in_height_q;
	end

	assign total    = (2*DIM_BITS)'(w) * (2*DIM_BITS)'(h);
	assign complete = !((2*DIM_BITS)'(load_count_q) < total);

	assign mode = dir_mode_q[2] ? KEEP_LANDSCAPE : pass_mode_q;
	assign pt   = (mode == KEEP_LANDSCAPE && w >= h) || (mode == KEEP_PORTRAIT && w <= h);
	assign outw = pt ? w : h;
	assign outh = pt ? h : w;

	assign wrap = ({1'b0, out_row_q} >= outh) || ({1'b0, out_col_q} >= outw);
	assign r    = wrap ? '0 : out_row_q;
	assign c    = wrap ? '0 : out_col_q;

	assign scol = dir_mode_q[1] ? POS_BITS'(outh - DIM_BITS'(1) - {1'b0, r}) : r;
	assign srow = dir_mode_q[0] ? POS_BITS'(h - DIM_BITS'(1) - {1'b0, c}) : c;

	assign row_sel = pt ? r : srow;
	assign col_sel = pt ? c : scol;
	assign rd_addr = CNT_BITS'(CNT_BITS'(row_sel) * CNT_BITS'(w)) + CNT_BITS'(col_sel);

	assign last    = ({1'b0, r} == outh - DIM_BITS'(1)) && ({1'b0, c} == outw - DIM_BITS'(1));
	assign col_end = ({1'b0, c} + DIM_BITS'(1)) >= outw;

	assign full    = q_stat.full;
	assign accept  = push && !full;
	assign is_load = (cmd == CMD_LOAD);
	assign q_push  = accept && (is_load ? !complete : complete);

	always_comb begin
		q_req.wr   = is_load;
		q_req.addr = is_load ? load_count_q[ADDR_BITS-1:0] : rd_addr[ADDR_BITS-1:0];
		q_req.data = pixel_in & PIX_MASK;
		q_req.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q  <= DIM_BITS'(8);
			in_height_q <= DIM_BITS'(8);
			dir_mode_q  <= '0;
			pass_mode_q <= PASS_ALWAYS;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IN_WIDTH:  in_width_q  <= cfg_data;
				REG_IN_HEIGHT: in_height_q <= cfg_data;
				REG_DIR_MODE:  dir_mode_q  <= cfg_data[2:0];
				REG_PASS_MODE: pass_mode_q <= cfg_data[1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
		end else if (q_push) begin
			if (is_load) begin
				load_count_q <= load_count_q + CNT_BITS'(1);
			end else if (last) begin
				load_count_q <= '0;
				out_row_q    <= '0;
				out_col_q    <= '0;
			end else if (col_end) begin
				out_col_q <= '0;
				out_row_q <= r + POS_BITS'(1);
			end else begin
				out_col_q <= c + POS_BITS'(1);
				out_row_q <= r;
			end
		end
	end

endmodule

FILE: src/ipt_queue.sv
// ----------------------------------------------------------------------------
// ipt_queue
// Two-entry queue of store requests between front and back.
// ----------------------------------------------------------------------------
module ipt_queue import ipt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  mem_req_t din,
	input  logic     pop,
	output mem_req_t dout,
	output q_stat_t  stat
);

	mem_req_t   entry_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign dout       = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= ~wptr_q;
			if (do_pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

FILE: src/ipt_back.sv
// ----------------------------------------------------------------------------
// ipt_back
// Frame store and result queue: applies store writes, performs reads and
// buffers results for the receiver.
// ----------------------------------------------------------------------------
module ipt_back import ipt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t q_req,
	input  q_stat_t  q_stat,
	output logic     q_pop,
	input  logic     pop,
	output logic     empty,
	output logic [63:0] pixel_out,
	output logic     frame_last
);

	localparam int OQ_PTR = $clog2(OQ_DEPTH);
	localparam int OQ_CNT = $clog2(OQ_DEPTH + 1);

	pixel_t    mem [STORE_DEPTH];
	pixel_t    rd_data_s1;
	logic      rd_v_s1, last_s1;
	out_item_t oq_q [OQ_DEPTH];
	logic [OQ_PTR-1:0] owptr_q, orptr_q;
	logic [OQ_CNT-1:0] ocnt_q;
	logic      room, issue, opop;

	assign room  = (OQ_CNT'(ocnt_q) + OQ_CNT'(rd_v_s1)) < OQ_CNT'(OQ_DEPTH);
	assign issue = !q_stat.empty && (q_req.wr || room);
	assign q_pop = issue;

	always_ff @(posedge clk) begin
		if (issue && q_req.wr) mem[q_req.addr] <= q_req.data;
		if (issue && !q_req.wr) begin
			rd_data_s1 <= mem[q_req.addr];
			last_s1    <= q_req.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_v_s1 <= 1'b0;
		else rd_v_s1 <= issue && !q_req.wr;
	end

	assign empty      = (ocnt_q == '0);
	assign opop       = pop && !empty;
	assign pixel_out  = oq_q[orptr_q].pixel;
	assign frame_last = oq_q[orptr_q].last;

	always_ff @(posedge clk) begin
		if (rd_v_s1) oq_q[owptr_q] <= '{pixel: rd_data_s1 & PIX_MASK, last: last_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= '0;
			orptr_q <= '0;
			ocnt_q  <= '0;
		end else begin
			if (rd_v_s1) owptr_q <= owptr_q + OQ_PTR'(1);
			if (opop) orptr_q <= orptr_q + OQ_PTR'(1);
			ocnt_q <= ocnt_q + OQ_CNT'(rd_v_s1) - OQ_CNT'(opop);
		end
	end

endmodule

FILE: src/image_plane_transpose.sv
// ----------------------------------------------------------------------------
// image_plane_transpose
// Frame-store plane transposer, optional row/column reversal, passthrough.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter as a queue: push with cmd/pixel_in, taken when full is low.
//   cmd load writes the next raster pixel of the frame (ignored once loaded);
//   cmd emit returns the next output pixel once the frame is loaded, and
//   nothing before that. Results leave as a queue: pixel_out/frame_last are
//   valid while empty is low and are taken with pop.
//   Config: cfg_we writes cfg_data into register cfg_index (in_width,
//   in_height, dir_mode, pass_mode); write only while the block is idle.
//   Throughput: one request per cycle while full is low, loads and emits
//   alike, limited by the single store port and the two-entry request queue.
//   An emit's result passes through the request queue, the store read
//   register and the result queue before it shows on pixel_out.
//   Reset clears counters and position and sets config to its defaults; the
//   store holds no valid data until loaded, so no clearing pass is run.
//   When the receiver stalls the four-entry result queue fills, then the
//   request queue, and full rises until pop frees space.
// ----------------------------------------------------------------------------
module image_plane_transpose import ipt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                cmd,
	input  logic [63:0]         pixel_in,
	input  logic                pop,
	output logic                empty,
	output logic [63:0]         pixel_out,
	output logic                frame_last,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);

	q_stat_t  q_stat;
	mem_req_t req_in, req_out;
	logic     q_push, q_pop;

	ipt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.cmd       (cmd),
		.pixel_in  (pixel_in),
		.full      (full),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_req     (req_in)
	);

	ipt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (req_in),
		.pop    (q_pop),
		.dout   (req_out),
		.stat   (q_stat)
	);

	ipt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_req      (req_out),
		.q_stat     (q_stat),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.pixel_out  (pixel_out),
		.frame_last (frame_last)
	);

endmodule

FILE: src/ipt_checker.sv
// ----------------------------------------------------------------------------
// ipt_checker
// Port-level checks of the plane transposer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipt_checker import ipt_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input logic                cmd,
	input logic                pop,
	input logic                empty,
	input logic [63:0]         pixel_out,
	input logic                frame_last
);

	// emits taken minus results taken, saturating
	logic [31:0] pend_q;
	logic        emit_in, res_out;

	assign emit_in = push && !full && (cmd == CMD_EMIT);
	assign res_out = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '0;
		else if (emit_in && !res_out && pend_q != '1) pend_q <= pend_q + 32'd1;
		else if (!emit_in && res_out && pend_q != '0) pend_q <= pend_q - 32'd1;
	end

	`IPT_ASSERT(a_hold, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(pixel_out) && $stable(frame_last)), "result changed while stalled")
	`IPT_ASSERT_IMP(a_pop_pend, clk, arst_n, res_out, pend_q != '0, "result taken without emit")
	`IPT_ASSERT_IMP(a_show_pend, clk, arst_n, !empty, pend_q != '0, "result shown without emit")

endmodule

bind image_plane_transpose ipt_checker u_chk (.*);
